FILE: sv/tid_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tid_pkg
// Shared types, codes and the three-digit-MNC country table of the TBCD IMSI
// decoder.
// ----------------------------------------------------------------------------
package tid_pkg;

  localparam int unsigned FIELD_DIGITS  = 15;
  localparam int unsigned STORE_W       = 60;
  localparam int unsigned COUNT_W       = 5;
  localparam int unsigned MCC_W         = 10;
  localparam int unsigned MSIN_W        = 40;
  localparam int unsigned OUT_DATA_W    = 128;
  localparam int unsigned QUEUE_DEPTH   = 4;
  localparam int unsigned MCC_TABLE_LEN = 29;
  localparam logic [MCC_W-1:0] MCC_LOW  = 10'd200;
  localparam logic [MCC_W-1:0] MCC_HIGH = 10'd799;
  localparam logic [3:0] FILLER         = 4'hF;
  localparam logic [3:0] MAX_DIGIT      = 4'd9;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_BAD_DIGIT = 2'd1,
    STATUS_BAD_COUNT = 2'd2,
    STATUS_BAD_MCC   = 2'd3
  } status_t;

  // one finished field, front to back
  typedef struct packed {
    logic               bad_digit;
    logic               count_ok;
    logic [STORE_W-1:0] store;
  } field_t;

  localparam int unsigned FIELD_W = $bits(field_t);

  localparam logic [MCC_W-1:0] MCC_TABLE [MCC_TABLE_LEN] = '{
    10'd302, 10'd310, 10'd311, 10'd312, 10'd313, 10'd316, 10'd334, 10'd338,
    10'd342, 10'd344, 10'd346, 10'd348, 10'd350, 10'd352, 10'd354, 10'd356,
    10'd358, 10'd360, 10'd362, 10'd363, 10'd364, 10'd365, 10'd366, 10'd368,
    10'd370, 10'd372, 10'd374, 10'd376, 10'd732
  };

  function automatic logic mnc_three_digits(input logic [MCC_W-1:0] mcc);
    logic hit;
    hit = 1'b0;
    for (int i = 0; i < MCC_TABLE_LEN; i++) begin
      if (MCC_TABLE[i] == mcc) hit = 1'b1;
    end
    return hit;
  endfunction

endpackage
`default_nettype wire

FILE: sv/tid_fifo.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tid_fifo
// Small synchronous queue of finished fields between front and back.
// ----------------------------------------------------------------------------
module tid_fifo #(
  parameter int unsigned WIDTH = tid_pkg::FIELD_W,
  parameter int unsigned DEPTH = tid_pkg::QUEUE_DEPTH
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] wr_data,
  output logic                  full,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      rd_data,
  output logic                  empty
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule
`default_nettype wire

FILE: sv/tid_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tid_front
// Takes TBCD bytes, collects digits up to the filler, flags bad digits and
// queues one finished field on the last byte.
// ----------------------------------------------------------------------------
module tid_front (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          s_tvalid,
  output logic               s_tready,
  input  wire logic [7:0]    s_tdata,   // [7:0] tbcd_byte
  input  wire logic          s_tlast,   // last_byte
  output logic               push,
  output tid_pkg::field_t    field,
  input  wire logic          queue_full
);

  typedef struct packed {
    logic [tid_pkg::STORE_W-1:0] store;
    logic [tid_pkg::COUNT_W-1:0] count;
    logic                        filler;
    logic                        bad;
  } acc_t;

  acc_t acc;
  acc_t acc_next;
  acc_t after_lo;
  logic accept;

  function automatic acc_t take_nibble(input acc_t a, input logic [3:0] nib);
    acc_t r;
    r = a;
    if (!a.filler && !a.bad) begin
      if (nib == tid_pkg::FILLER) begin
        r.filler = 1'b1;
      end else if (nib > tid_pkg::MAX_DIGIT) begin
        r.bad = 1'b1;
      end else begin
        if (a.count < tid_pkg::COUNT_W'(tid_pkg::FIELD_DIGITS))
          r.store = {a.store[tid_pkg::STORE_W-5:0], nib};
        if (a.count <= tid_pkg::COUNT_W'(tid_pkg::FIELD_DIGITS))
          r.count = a.count + 1'b1;
      end
    end
    return r;
  endfunction

  assign s_tready = !queue_full;
  assign accept   = s_tvalid && s_tready;
  assign after_lo = take_nibble(acc, s_tdata[3:0]);
  assign acc_next = take_nibble(after_lo, s_tdata[7:4]);

  assign push  = accept && s_tlast;
  assign field = {acc_next.bad,
                  (acc_next.count == tid_pkg::COUNT_W'(tid_pkg::FIELD_DIGITS)),
                  acc_next.store};

  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= '0;
    end else if (accept) begin
      acc <= s_tlast ? '0 : acc_next;
    end
  end

endmodule
`default_nettype wire

FILE: sv/tid_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tid_back
// Splits a queued field into MCC, MNC and MSIN over two stages; the second
// stage is the output register.
// ----------------------------------------------------------------------------
module tid_back (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            queue_empty,
  input  wire tid_pkg::field_t                 field,
  output logic                                 pop,
  output logic                                 m_tvalid,
  input  wire logic                            m_tready,
  output logic [tid_pkg::OUT_DATA_W-1:0]       m_tdata,  // [9:0] mcc, [19:10] mnc,
                                                         // [21:20] mnc_digits,
                                                         // [61:22] msin_bcd,
                                                         // [121:62] imsi_bcd
  output logic [1:0]                           m_tuser   // [1:0] status
);

  localparam int unsigned MW = tid_pkg::MCC_W;
  localparam int unsigned SW = tid_pkg::STORE_W;

  logic                a_valid;
  tid_pkg::status_t    a_status;
  logic [MW-1:0]       a_mcc;
  logic [MW-1:0]       a_mnc2;
  logic [MW-1:0]       a_mnc3;
  logic [SW-1:0]       a_store;
  logic                a_adv;
  logic                b_adv;

  logic [3:0]          d0, d1, d2, d3, d4, d5;
  logic [MW-1:0]       mcc_c;
  tid_pkg::status_t    status_c;

  logic                three;
  logic                computed;
  logic [MW-1:0]       mnc_c;
  logic [1:0]          mlen_c;
  logic [tid_pkg::MSIN_W-1:0] msin_c;

  assign d0 = field.store[59:56];
  assign d1 = field.store[55:52];
  assign d2 = field.store[51:48];
  assign d3 = field.store[47:44];
  assign d4 = field.store[43:40];
  assign d5 = field.store[39:36];

  assign mcc_c = (MW'(d0) * MW'(100)) + (MW'(d1) * MW'(10)) + MW'(d2);

  always_comb begin
    if (field.bad_digit)
      status_c = tid_pkg::STATUS_BAD_DIGIT;
    else if (!field.count_ok)
      status_c = tid_pkg::STATUS_BAD_COUNT;
    else if (mcc_c < tid_pkg::MCC_LOW || mcc_c > tid_pkg::MCC_HIGH)
      status_c = tid_pkg::STATUS_BAD_MCC;
    else
      status_c = tid_pkg::STATUS_OK;
  end

  assign b_adv = !m_tvalid || m_tready;
  assign a_adv = !a_valid || b_adv;
  assign pop   = a_adv && !queue_empty;

  always_ff @(posedge clk) begin
    if (pop) begin
      a_status <= status_c;
      a_mcc    <= mcc_c;
      a_mnc2   <= (MW'(d3) * MW'(10)) + MW'(d4);
      a_mnc3   <= (MW'(d3) * MW'(100)) + (MW'(d4) * MW'(10)) + MW'(d5);
      a_store  <= field.store;
    end
  end

  assign computed = (a_status == tid_pkg::STATUS_OK) || (a_status == tid_pkg::STATUS_BAD_MCC);
  assign three    = tid_pkg::mnc_three_digits(a_mcc);

  always_comb begin
    if (!computed) begin
      mnc_c  = '0;
      mlen_c = 2'd2;
      msin_c = '0;
    end else if (three) begin
      mnc_c  = a_mnc3;
      mlen_c = 2'd3;
      msin_c = {4'd0, a_store[35:0]};
    end else begin
      mnc_c  = a_mnc2;
      mlen_c = 2'd2;
      msin_c = a_store[39:0];
    end
  end

  always_ff @(posedge clk) begin
    if (a_valid && b_adv) begin
      m_tuser <= a_status;
      m_tdata <= {6'd0,
                  computed ? a_store : {SW{1'b0}},
                  msin_c, mlen_c, mnc_c,
                  computed ? a_mcc : {MW{1'b0}}};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid  <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (a_adv)  a_valid  <= !queue_empty;
      if (b_adv)  m_tvalid <= a_valid;
    end
  end

  a_bad_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == tid_pkg::STATUS_BAD_DIGIT || m_tuser == tid_pkg::STATUS_BAD_COUNT)
    |-> m_tdata[121:62] == '0 && m_tdata[21:20] == 2'd2 && m_tdata[9:0] == '0)
    else $error("rejected field carries digits");

  a_ok_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == tid_pkg::STATUS_OK
    |-> m_tdata[9:0] >= tid_pkg::MCC_LOW && m_tdata[9:0] <= tid_pkg::MCC_HIGH)
    else $error("ok status with MCC out of range");

  a_mnc_len: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[21:20] == 2'd2 |-> m_tdata[19:10] < 10'd100)
    else $error("two-digit MNC above 99");

  a_stage_hold: assert property (@(posedge clk) disable iff (rst)
    a_valid && !b_adv |=> a_valid && $stable(a_mcc) && $stable(a_store))
    else $error("split stage lost a stalled field");

endmodule
`default_nettype wire

FILE: sv/tbcd_imsi_decoder.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tbcd_imsi_decoder
// Decodes a TBCD IMSI field, one byte per request, into status, MCC, MNC,
// MNC length, MSIN and IMSI.
//
//   channel   dir  tdata                          tuser    tlast
//   s_*       in   [7:0] tbcd_byte                -        last_byte
//   m_*       out  mcc,mnc,mnc_digits,msin,imsi   status   -
//
// One byte request per cycle sustained while the queue of finished fields is
// not full; the front handles both nibbles in the cycle it takes the byte.
// The finished field is written into the queue on the same edge that takes the
// last byte, then passes the split stage and the output register to reach m_*.
// Synchronous reset clears the digit state, the queue and both back stages.
// A stalled output backs up the back stages and then the queue; s_tready
// drops only when the queue of finished fields is full.
// ----------------------------------------------------------------------------
module tbcd_imsi_decoder #(
  parameter int unsigned QUEUE_DEPTH = tid_pkg::QUEUE_DEPTH
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       s_tvalid,
  output logic                            s_tready,
  input  wire logic [7:0]                 s_tdata,  // [7:0] tbcd_byte
  input  wire logic                       s_tlast,  // last_byte
  output logic                            m_tvalid,
  input  wire logic                       m_tready,
  output logic [tid_pkg::OUT_DATA_W-1:0]  m_tdata,  // [9:0] mcc, [19:10] mnc,
                                                    // [21:20] mnc_digits,
                                                    // [61:22] msin_bcd,
                                                    // [121:62] imsi_bcd
  output logic [1:0]                      m_tuser   // [1:0] status
);

  logic            push;
  logic            pop;
  logic            full;
  logic            empty;
  tid_pkg::field_t wr_field;
  tid_pkg::field_t rd_field;

  tid_front u_front (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tlast    (s_tlast),
    .push       (push),
    .field      (wr_field),
    .queue_full (full)
  );

  tid_fifo #(
    .WIDTH (tid_pkg::FIELD_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .wr_data (wr_field),
    .full    (full),
    .pop     (pop),
    .rd_data (rd_field),
    .empty   (empty)
  );

  tid_back u_back (
    .clk         (clk),
    .rst         (rst),
    .queue_empty (empty),
    .field       (rd_field),
    .pop         (pop),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser)
  );

endmodule
`default_nettype wire

FILE: sim/tbcd_imsi_decoder_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbcd_imsi_decoder_tb
// Drives TBCD IMSI fields into the decoder a byte per request and checks every
// decoded result against a cycle-free predictor kept in step with the input
// handshake. Covers short, empty, overlong and bad-digit fields, bytes after
// the filler, MCC range edges and both MNC lengths, under random idling on
// both sides and one long output hold-off that backs up the input.
// ----------------------------------------------------------------------------
module tbcd_imsi_decoder_tb;

  localparam int HOLD_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT = 3000;

  typedef struct packed {
    tid_pkg::status_t status;
    logic [9:0]  mcc;
    logic [9:0]  mnc;
    logic [1:0]  mnc_len;
    logic [39:0] msin;
    logic [59:0] imsi;
  } imsi_result_t;

  logic         clk;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [7:0]   s_tdata = 8'h00;
  logic         s_tlast = 1'b0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [127:0] m_tdata;
  logic [1:0]   m_tuser;

  // predictor state for the field in flight
  logic [59:0]  field_digits = '0;
  logic [4:0]   digit_total = '0;
  logic         filler_hit = 1'b0;
  logic         bad_hit = 1'b0;

  imsi_result_t pending_results[$];
  logic [3:0]   nib_q[$];

  int send_idle = 0;
  int recv_idle = 0;
  int hold_reqs = 0;
  int hold_done = 0;
  int hold_left = 0;
  int errors = 0;
  int bytes_sent = 0;
  int stall_cycles = 0;

  tbcd_imsi_decoder uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic bit has_three_digit_mnc(input int mcc);
    case (mcc)
      302, 310, 311, 312, 313, 316, 334, 338, 342, 344,
      346, 348, 350, 352, 354, 356, 358, 360, 362, 363,
      364, 365, 366, 368, 370, 372, 374, 376, 732: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  function automatic void take_nibble(input logic [3:0] nib);
    if (filler_hit || bad_hit) return;
    if (nib == tid_pkg::FILLER) begin
      filler_hit = 1'b1;
      return;
    end
    if (nib > tid_pkg::MAX_DIGIT) begin
      bad_hit = 1'b1;
      return;
    end
    if (digit_total < 15) field_digits = {field_digits[55:0], nib};
    if (digit_total < 16) digit_total = digit_total + 1'b1;
  endfunction

  function automatic logic [3:0] digit_at(input int k);
    return field_digits[(14 - k) * 4 +: 4];
  endfunction

  function automatic imsi_result_t decode_field();
    imsi_result_t r;
    int mcc_v;
    int mnc_v;
    r.status  = tid_pkg::STATUS_OK;
    r.mcc     = '0;
    r.mnc     = '0;
    r.mnc_len = 2'd2;
    r.msin    = '0;
    r.imsi    = '0;
    if (bad_hit) begin
      r.status = tid_pkg::STATUS_BAD_DIGIT;
    end else if (digit_total != tid_pkg::FIELD_DIGITS) begin
      r.status = tid_pkg::STATUS_BAD_COUNT;
    end else begin
      mcc_v = digit_at(0) * 100 + digit_at(1) * 10 + digit_at(2);
      if (mcc_v < tid_pkg::MCC_LOW || mcc_v > tid_pkg::MCC_HIGH)
        r.status = tid_pkg::STATUS_BAD_MCC;
      else
        r.status = tid_pkg::STATUS_OK;
      r.mnc_len = has_three_digit_mnc(mcc_v) ? 2'd3 : 2'd2;
      mnc_v = 0;
      for (int i = 0; i < r.mnc_len; i++) mnc_v = mnc_v * 10 + digit_at(3 + i);
      r.mcc  = mcc_v[9:0];
      r.mnc  = mnc_v[9:0];
      r.msin = (r.mnc_len == 2'd3) ? {4'h0, field_digits[35:0]} : field_digits[39:0];
      r.imsi = field_digits;
    end
    return r;
  endfunction

  // predictor and result check
  always @(posedge clk) begin
    imsi_result_t got;
    imsi_result_t want;
    if (!rst && s_tvalid && s_tready) begin
      take_nibble(s_tdata[3:0]);
      take_nibble(s_tdata[7:4]);
      if (s_tlast) begin
        pending_results.push_back(decode_field());
        field_digits = '0;
        digit_total  = '0;
        filler_hit   = 1'b0;
        bad_hit      = 1'b0;
      end
    end
    if (!rst && m_tvalid && m_tready) begin
      got.status  = tid_pkg::status_t'(m_tuser);
      got.mcc     = m_tdata[9:0];
      got.mnc     = m_tdata[19:10];
      got.mnc_len = m_tdata[21:20];
      got.msin    = m_tdata[61:22];
      got.imsi    = m_tdata[121:62];
      if (pending_results.size() == 0) begin
        errors++;
        if (errors <= 10) $display("%0t: result with no field pending", $time);
      end else begin
        want = pending_results.pop_front();
        if (got !== want) begin
          errors++;
          if (errors <= 10) begin
            $display("%0t: expected status %0d mcc %0d mnc %0d len %0d msin %h imsi %h",
                     $time, want.status, want.mcc, want.mnc, want.mnc_len, want.msin,
                     want.imsi);
            $display("%0t: actual   status %0d mcc %0d mnc %0d len %0d msin %h imsi %h",
                     $time, got.status, got.mcc, got.mnc, got.mnc_len, got.msin, got.imsi);
          end
        end
      end
    end
  end

  // output side: random idling plus requested hold-offs
  always @(posedge clk) begin
    if (hold_done != hold_reqs) begin
      hold_done++;
      hold_left = HOLD_CYCLES;
    end
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(0, 99) >= recv_idle);
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) stall_cycles = 0;
    else stall_cycles++;
    if (stall_cycles == WATCHDOG_LIMIT) begin
      $display("tbcd_imsi_decoder_tb failed");
      $finish;
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic l);
    while ($urandom_range(0, 99) < send_idle) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tlast  <= l;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    bytes_sent++;
  endtask

  // drains nib_q as one field, low nibble first, odd tail padded with filler
  task automatic send_field();
    logic [3:0] lo;
    logic [3:0] hi;
    if (nib_q.size() == 0) nib_q.push_back(tid_pkg::FILLER);
    if (nib_q.size() % 2) nib_q.push_back(tid_pkg::FILLER);
    while (nib_q.size() != 0) begin
      lo = nib_q.pop_front();
      hi = nib_q.pop_front();
      send_byte({hi, lo}, nib_q.size() == 0);
    end
  endtask

  function automatic void push_text(input string s);
    logic [7:0] c;
    for (int i = 0; i < s.len(); i++) begin
      c = s[i];
      nib_q.push_back(4'(c >= 8'h41 ? c - 8'h37 : c - 8'h30));
    end
  endfunction

  function automatic void push_digits(input int n);
    repeat (n) nib_q.push_back(4'($urandom_range(0, 9)));
  endfunction

  function automatic void push_noise(input int n);
    repeat (n) nib_q.push_back(4'($urandom_range(0, 15)));
  endfunction

  function automatic int pick_mcc();
    int sel;
    int m;
    sel = $urandom_range(0, 99);
    if (sel < 35) begin
      if ($urandom_range(0, 9) == 0) return 732;
      do m = $urandom_range(302, 376); while (!has_three_digit_mnc(m));
      return m;
    end
    if (sel < 45) begin
      case ($urandom_range(0, 5))
        0: return 0;
        1: return 199;
        2: return 200;
        3: return 799;
        4: return 800;
        default: return 999;
      endcase
    end
    if (sel < 85) return $urandom_range(200, 799);
    return $urandom_range(0, 999);
  endfunction

  task automatic send_random_field();
    int kind;
    int mcc;
    int tail;
    kind = $urandom_range(0, 99);
    if (kind < 75) begin
      mcc = pick_mcc();
      nib_q.push_back(4'(mcc / 100));
      nib_q.push_back(4'((mcc / 10) % 10));
      nib_q.push_back(4'(mcc % 10));
      push_digits(12);
      tail = $urandom_range(0, 9);
      if (tail < 7) nib_q.push_back(tid_pkg::FILLER);
      else if (tail < 9) push_digits($urandom_range(1, 3));
      else nib_q.push_back(4'($urandom_range(10, 14)));
      if ($urandom_range(0, 3) == 0) push_noise($urandom_range(1, 6));
    end else if (kind < 85) begin
      push_digits($urandom_range(0, 20));
      if ($urandom_range(0, 1)) nib_q.push_back(tid_pkg::FILLER);
    end else if (kind < 93) begin
      push_digits($urandom_range(0, 14));
      nib_q.push_back(4'($urandom_range(10, 14)));
      push_noise($urandom_range(0, 4));
    end else begin
      push_noise($urandom_range(1, 16));
    end
    send_field();
  endtask

  // empty field, two digits only, bad digit in a single byte
  task automatic test_short_fields();
    send_byte(8'hFF, 1'b1);
    send_byte(8'h00, 1'b1);
    send_byte(8'hE5, 1'b1);
  endtask

  task automatic test_full_fields();
    // three-digit MNC, then a byte after the filler that must be ignored
    push_text("310260123456789FBA");
    send_field();
    // sixteen digits, no filler
    push_text("2009876543210987");
    send_field();
    // MCC above range, two-digit MNC
    push_text("999999999999999F");
    send_field();
  endtask

  task automatic test_random(input int byte_target);
    int start;
    start = bytes_sent;
    while (bytes_sent - start < byte_target) send_random_field();
  endtask

  // output held off while single-byte fields keep coming
  task automatic test_backpressure();
    hold_reqs++;
    repeat (40) send_byte(8'($urandom_range(0, 255)), 1'b1);
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    send_idle = 29;
    recv_idle = 86;
    test_short_fields();
    test_full_fields();
    test_random(440);
    send_idle = 86;
    recv_idle = 29;
    test_random(440);
    send_idle = 0;
    recv_idle = 0;
    test_backpressure();
    test_random(440);
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("tbcd_imsi_decoder_tb passed");
    end else begin
      $display("tbcd_imsi_decoder_tb failed");
    end
    $finish;
  end

endmodule
